// File: hw/rtl/xtea_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the XTEA block decrypt core.
// Used by xtea_round_unit, xtea_block_decrypt_core and xtea_checker; no dependencies.

package xtea_pkg;

   localparam int WORD_W   = 32;
   localparam int ROUND_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int BLOCK_W  = 2 * WORD_W;
   localparam int KEY_WORDS = 4;

   localparam logic [WORD_W-1:0]  DELTA = 32'h9E37_79B9;
   localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 8'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROUND_COUNT = 3'd0,
      CSR_KEY_WORD_0  = 3'd1,
      CSR_KEY_WORD_1  = 3'd2,
      CSR_KEY_WORD_2  = 3'd3,
      CSR_KEY_WORD_3  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] mix_src;
      logic [WORD_W-1:0] target;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] key;
   } round_op_type;

endpackage

// File: hw/rtl/xtea_round_unit.sv
`timescale 1ns / 1ps
// Shared XTEA half-round datapath: target - (mix(src) ^ (sum + key)).
// Depends on xtea_pkg.

module xtea_round_unit
   import xtea_pkg::*;
(
   input  round_op_type      op,
   output logic [WORD_W-1:0] result
);

   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] sum_key;

   assign mix     = ((op.mix_src << 4) ^ (op.mix_src >> 5)) + op.mix_src;
   assign sum_key = op.sum + op.key;
   assign result  = op.target - (mix ^ sum_key);

endmodule

// File: hw/rtl/xtea_block_decrypt_core.sv
`timescale 1ns / 1ps
// XTEA 64-bit block decryption core with register-programmed key and round count.
// Depends on xtea_pkg and xtea_round_unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   req_    | in        | req_tvalid/tready    | tdata: cipher_first, cipher_second
//   rsp_    | out       | rsp_tvalid/tready    | tdata: plain_first, plain_second
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One half-round per cycle through a single shared round unit: a request with
// N rounds runs two half-rounds per round; N=0 goes straight to the response.
// req_tready is low from acceptance until the response is taken.
// A stalled response holds in its output register. Reset is synchronous and
// restores round_count to 64 and the key to zero; csr_ready is always high.

module xtea_block_decrypt_core
   import xtea_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BLOCK_W-1:0]   req_tdata,   // [31:0] cipher_first, [63:32] cipher_second

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BLOCK_W-1:0]   rsp_tdata,   // [31:0] plain_first, [63:32] plain_second

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   state_type            state_ff, state_in;
   logic [ROUND_W-1:0]   round_count_ff;
   logic [WORD_W-1:0]    key_ff [KEY_WORDS];
   logic [WORD_W-1:0]    a_ff, b_ff, sum_ff;
   logic [ROUND_W-1:0]   count_ff;
   logic                 phase_ff;

   logic                 req_accept;
   logic                 csr_write;
   logic [WORD_W-1:0]    sum_init;
   logic [1:0]           key_sel;
   round_op_type         op;
   logic [WORD_W-1:0]    unit_result;

   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_valid && csr_ready;
   assign sum_init   = DELTA * WORD_W'(round_count_ff);

   always_comb begin
      key_sel    = phase_ff ? sum_ff[1:0] : sum_ff[12:11];
      op.mix_src = phase_ff ? b_ff : a_ff;
      op.target  = phase_ff ? a_ff : b_ff;
      op.sum     = sum_ff;
      op.key     = key_ff[key_sel];
   end

   xtea_round_unit u_round (
      .op     (op),
      .result (unit_result)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (round_count_ff == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (phase_ff && count_ff == ROUND_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DONE: rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   assign rsp_tdata = {b_ff, a_ff};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         round_count_ff <= ROUND_COUNT_RESET;
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               CSR_ROUND_COUNT: round_count_ff <= csr_data[ROUND_W-1:0];
               CSR_KEY_WORD_0:  key_ff[0] <= csr_data;
               CSR_KEY_WORD_1:  key_ff[1] <= csr_data;
               CSR_KEY_WORD_2:  key_ff[2] <= csr_data;
               CSR_KEY_WORD_3:  key_ff[3] <= csr_data;
               default: ;
            endcase
         end
         if (req_accept) begin
            count_ff <= round_count_ff;
            phase_ff <= 1'b0;
         end else if (state_ff == ST_RUN) begin
            if (phase_ff) begin
               count_ff <= count_ff - ROUND_W'(1);
            end
            phase_ff <= ~phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_ff   <= req_tdata[WORD_W-1:0];
         b_ff   <= req_tdata[BLOCK_W-1:WORD_W];
         sum_ff <= sum_init;
      end else if (state_ff == ST_RUN) begin
         if (phase_ff) begin
            a_ff <= unit_result;
         end else begin
            b_ff   <= unit_result;
            sum_ff <= sum_ff - DELTA;
         end
      end
   end

endmodule

// File: hw/rtl/xtea_checker.sv
`timescale 1ns / 1ps
// Port-level checks for xtea_block_decrypt_core, bound onto the top level.
// Depends on xtea_pkg and xtea_block_decrypt_core.

module xtea_checker
   import xtea_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [BLOCK_W-1:0]   rsp_tdata
);

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready stayed high after a request was accepted");

   a_idle_after_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> (req_tready && !rsp_tvalid))
      else $error("core did not return to idle after the response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response dropped or changed");

endmodule

bind xtea_block_decrypt_core xtea_checker u_xtea_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
